[hdl/assert_macros.svh]
// Assertion macros used by the module that checks its own behavior
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge of clk outside reset
`define CHK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent, outside reset
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error(msg);

`endif

[hdl/etva_pkg.sv]
// Types, widths and command codes for the edge-to-vertex averaging block
package etva_pkg;

	localparam int VERT_W   = 12;
	localparam int EDGE_W   = 14;
	localparam int VAL_W    = 32;
	localparam int SUM_W    = 48;
	localparam int CNT_W    = 16;
	localparam int N_VERT   = 4096;
	localparam int N_EDGE   = 16384;
	localparam int DIV_CW   = 6;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_FACE  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [1:0]        command;
		logic [EDGE_W-1:0] edge_index;
		logic signed [VAL_W-1:0] edge_value;
		logic [VERT_W-1:0] face_vertex_a;
		logic [VERT_W-1:0] face_vertex_b;
		logic [VERT_W-1:0] face_vertex_c;
		logic [EDGE_W-1:0] face_edge_a;
		logic [EDGE_W-1:0] face_edge_b;
		logic [EDGE_W-1:0] face_edge_c;
		logic [2:0]        corner_skip;
	} item_t;

	typedef struct packed {
		logic [VERT_W-1:0]       vertex_id;
		logic signed [VAL_W-1:0] average;
		logic [CNT_W-1:0]        valence;
		logic                    overflow;
	} result_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [CNT_W-1:0]        cnt;
	} vrec_t;

	// Corner that receives a contribution: (j + 1 + h) mod 3
	function automatic logic [1:0] target_corner(input logic [1:0] j, input logic h);
		logic [1:0] r;
		case ({j, h})
			3'b000:  r = 2'd1;
			3'b001:  r = 2'd2;
			3'b010:  r = 2'd2;
			3'b011:  r = 2'd0;
			3'b100:  r = 2'd0;
			3'b101:  r = 2'd1;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

[hdl/edge_to_vertex_average.sv]
// Edge-to-vertex scatter average: edge store, vertex store, sequencer, serial divider
//
// channel  | handshake             | payload           | direction
// ---------+-----------------------+-------------------+----------
// command  | start, busy           | item   (item_t)   | in
// result   | done (1-cycle strobe) | result (result_t) | out
//
// A load item is written to the edge store on the accept edge; busy stays low.
// A face item walks its corners in order; a corner that is not skipped issues
// an edge read, then two read-modify-write passes, and a skipped corner only advances.
// A read item reads the vertex store, then runs the bit-serial divider over the
// whole sum (not if the valence is zero); done pulses as the result is loaded.
// Reset and a clear item sweep all 4096 vertex entries, one a cycle, busy high.
// The receiver cannot stall; done marks each result, held until the next one.
`include "assert_macros.svh"

module edge_to_vertex_average (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  etva_pkg::item_t   item,
	output logic              done,
	output etva_pkg::result_t result
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CLR    = 4'd1;
	localparam logic [3:0] ST_CORNER = 4'd2;
	localparam logic [3:0] ST_E_WT   = 4'd3;
	localparam logic [3:0] ST_V_RD   = 4'd4;
	localparam logic [3:0] ST_V_WR   = 4'd5;
	localparam logic [3:0] ST_R_RD   = 4'd6;
	localparam logic [3:0] ST_R_WT   = 4'd7;
	localparam logic [3:0] ST_DIV    = 4'd8;

	logic [3:0] state_q;
	etva_pkg::item_t item_q;
	logic [1:0] corner_q;
	logic       half_q;
	logic [etva_pkg::VERT_W-1:0] clr_addr_q;
	logic       ovf_q;
	logic       done_q;
	etva_pkg::result_t result_q;

	// edge store
	logic signed [etva_pkg::VAL_W-1:0] edge_mem [etva_pkg::N_EDGE];
	logic signed [etva_pkg::VAL_W-1:0] edge_rd_q;
	logic [etva_pkg::EDGE_W-1:0] edge_raddr;

	// vertex store: sum and valence side by side
	etva_pkg::vrec_t vert_mem [etva_pkg::N_VERT];
	etva_pkg::vrec_t vert_rd_q;
	logic [etva_pkg::VERT_W-1:0] vert_raddr;
	logic [etva_pkg::VERT_W-1:0] vert_waddr;
	etva_pkg::vrec_t vert_wdata;
	logic vert_we;

	// divider
	logic [etva_pkg::SUM_W-1:0] quo_q;
	logic [etva_pkg::CNT_W-1:0] rem_q;
	logic [etva_pkg::CNT_W-1:0] dvs_q;
	logic                       neg_q;
	logic [etva_pkg::DIV_CW-1:0] div_cnt_q;
	logic [etva_pkg::CNT_W:0]   rem_sh;
	logic [etva_pkg::CNT_W:0]   rem_sub;
	logic [etva_pkg::SUM_W-1:0] quo_nxt;
	logic [etva_pkg::VAL_W-1:0] quo_signed;

	logic accept;
	logic [1:0] tgt;
	logic [etva_pkg::VERT_W-1:0] tgt_vertex;
	logic [etva_pkg::EDGE_W-1:0] corner_edge;
	logic [etva_pkg::SUM_W-1:0] sum_abs;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;

	// pick the vertex that the current corner and half feed
	assign tgt = etva_pkg::target_corner(corner_q, half_q);
	always_comb begin
		case (tgt)
			2'd0:    tgt_vertex = item_q.face_vertex_a;
			2'd1:    tgt_vertex = item_q.face_vertex_b;
			default: tgt_vertex = item_q.face_vertex_c;
		endcase
		case (corner_q)
			2'd0:    corner_edge = item_q.face_edge_a;
			2'd1:    corner_edge = item_q.face_edge_b;
			default: corner_edge = item_q.face_edge_c;
		endcase
	end

	assign edge_raddr = corner_edge;
	assign vert_raddr = (state_q == ST_R_RD) ? item_q.face_vertex_a : tgt_vertex;

	// write port: clearing sweep or the accumulate step
	always_comb begin
		vert_we    = 1'b0;
		vert_waddr = tgt_vertex;
		vert_wdata = vert_rd_q;
		if (state_q == ST_CLR) begin
			vert_we    = 1'b1;
			vert_waddr = clr_addr_q;
			vert_wdata = '0;
		end else if (state_q == ST_V_WR && vert_rd_q.cnt != etva_pkg::CNT_MAX) begin
			vert_we        = 1'b1;
			vert_wdata.cnt = vert_rd_q.cnt + 1'b1;
			vert_wdata.sum = vert_rd_q.sum
				+ {{(etva_pkg::SUM_W-etva_pkg::VAL_W){edge_rd_q[etva_pkg::VAL_W-1]}},
				   edge_rd_q};
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.command == etva_pkg::CMD_LOAD) begin
			edge_mem[item.edge_index] <= item.edge_value;
		end
		edge_rd_q <= edge_mem[edge_raddr];
	end

	always_ff @(posedge clk) begin
		if (vert_we) begin
			vert_mem[vert_waddr] <= vert_wdata;
		end
		vert_rd_q <= vert_mem[vert_raddr];
	end

	// restoring division step: shift one dividend bit into the remainder
	assign rem_sh  = {rem_q, quo_q[etva_pkg::SUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign quo_nxt = {quo_q[etva_pkg::SUM_W-2:0], !rem_sub[etva_pkg::CNT_W]};
	// the last step's quotient bit is taken straight into the result
	assign quo_signed = neg_q ? (~quo_nxt[etva_pkg::VAL_W-1:0] + 1'b1)
	                          : quo_nxt[etva_pkg::VAL_W-1:0];
	assign sum_abs = vert_rd_q.sum[etva_pkg::SUM_W-1] ? (~vert_rd_q.sum + 1'b1)
	                                                  : vert_rd_q.sum;

	always_ff @(posedge clk) begin
		if (state_q == ST_R_WT) begin
			quo_q     <= sum_abs;
			rem_q     <= '0;
			dvs_q     <= vert_rd_q.cnt;
			neg_q     <= vert_rd_q.sum[etva_pkg::SUM_W-1];
		end else if (state_q == ST_DIV) begin
			if (!rem_sub[etva_pkg::CNT_W]) begin
				rem_q <= rem_sub[etva_pkg::CNT_W-1:0];
			end else begin
				rem_q <= rem_sh[etva_pkg::CNT_W-1:0];
			end
			quo_q <= quo_nxt;
		end
		if (accept) begin
			item_q <= item;
		end
	end

	// result register: hold the last result, strobe done for one cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_R_WT && vert_rd_q.cnt == '0) begin
			result_q.vertex_id <= item_q.face_vertex_a;
			result_q.average   <= '0;
			result_q.valence   <= '0;
			result_q.overflow  <= ovf_q;
		end else if (state_q == ST_DIV && div_cnt_q == '0) begin
			result_q.vertex_id <= item_q.face_vertex_a;
			result_q.average   <= quo_signed;
			result_q.valence   <= dvs_q;
			result_q.overflow  <= ovf_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_addr_q <= '0;
			corner_q   <= '0;
			half_q     <= 1'b0;
			ovf_q      <= 1'b0;
			done_q     <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						corner_q <= '0;
						half_q   <= 1'b0;
						case (item.command)
							etva_pkg::CMD_FACE:  state_q <= ST_CORNER;
							etva_pkg::CMD_READ:  state_q <= ST_R_RD;
							etva_pkg::CMD_CLEAR: begin
								clr_addr_q <= '0;
								state_q    <= ST_CLR;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_CLR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == etva_pkg::VERT_W'(etva_pkg::N_VERT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CORNER: begin
					// edge read issues here; a skipped corner only advances to the next corner here
					if (corner_q == 2'd3) begin
						state_q <= ST_IDLE;
					end else if (item_q.corner_skip[corner_q]) begin
						corner_q <= corner_q + 1'b1;
					end else begin
						half_q  <= 1'b0;
						state_q <= ST_E_WT;
					end
				end
				ST_E_WT: state_q <= ST_V_RD;
				ST_V_RD: state_q <= ST_V_WR;
				ST_V_WR: begin
					if (vert_rd_q.cnt == etva_pkg::CNT_MAX) begin
						ovf_q <= 1'b1;
					end
					if (!half_q) begin
						half_q  <= 1'b1;
						state_q <= ST_V_RD;
					end else begin
						half_q   <= 1'b0;
						corner_q <= corner_q + 1'b1;
						state_q  <= ST_CORNER;
					end
				end
				ST_R_RD: state_q <= ST_R_WT;
				ST_R_WT: begin
					if (vert_rd_q.cnt == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						div_cnt_q <= etva_pkg::DIV_CW'(etva_pkg::SUM_W - 1);
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q - 1'b1;
					if (div_cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`CHK_ALWAYS(a_done_idle, done_q |-> (state_q == ST_IDLE), "result strobe outside idle")
	`CHK_NEXT(a_done_single, done_q, !done_q, "result strobe held two cycles")
	`CHK_ALWAYS(a_no_wrap, (vert_we && state_q == ST_V_WR) |-> (vert_wdata.cnt != '0),
		"valence count wrapped")

endmodule

[dv/edge_to_vertex_average_tb.sv]
// Testbench for the edge-to-vertex scatter average: directed table, then random items
module edge_to_vertex_average_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 120;
	localparam int RANDOM_ITEMS   = 1130;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	etva_pkg::item_t   item;
	logic              done;
	etva_pkg::result_t result;

	edge_to_vertex_average dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	// Shadow copy of the block state
	logic [etva_pkg::VAL_W-1:0] edge_mem [etva_pkg::N_EDGE];
	bit               edge_written [etva_pkg::N_EDGE];
	longint           vertex_sum [etva_pkg::N_VERT];
	int unsigned      vertex_count [etva_pkg::N_VERT];
	bit               overflow_seen;
	int               loaded_edges[$];

	// Averages waiting for their done strobe
	etva_pkg::result_t pending_averages[$];

	int n_items;
	int n_reads;
	int n_faces;
	int n_clears;
	int n_results;
	int n_mismatch;
	int idle_cycles;

	typedef struct {
		etva_pkg::item_t   it;
		int                reps;
		bit                typed;
		etva_pkg::result_t want;
	} stim_row_t;

	stim_row_t directed[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void clear_vertices();
		for (int v = 0; v < etva_pkg::N_VERT; v++) begin
			vertex_sum[v]   = 0;
			vertex_count[v] = 0;
		end
	endfunction

	function automatic void add_to_vertex(input logic [etva_pkg::VERT_W-1:0] v,
			input longint val);
		if (vertex_count[v] >= 65535) begin
			overflow_seen = 1'b1;
		end else begin
			vertex_count[v] = vertex_count[v] + 1;
			vertex_sum[v]   = vertex_sum[v] + val;
		end
	endfunction

	// Advance the shadow state by one item; return the read result, if any
	function automatic bit average_predict(input etva_pkg::item_t it,
			output etva_pkg::result_t r);
		logic [etva_pkg::VERT_W-1:0] vtx [3];
		logic [etva_pkg::EDGE_W-1:0] edg [3];
		longint val;
		longint avg;
		r = '0;
		case (it.command)
			etva_pkg::CMD_LOAD: begin
				edge_mem[it.edge_index] = it.edge_value;
				if (!edge_written[it.edge_index]) begin
					edge_written[it.edge_index] = 1'b1;
					loaded_edges.push_back(int'(it.edge_index));
				end
				return 1'b0;
			end
			etva_pkg::CMD_FACE: begin
				vtx[0] = it.face_vertex_a;
				vtx[1] = it.face_vertex_b;
				vtx[2] = it.face_vertex_c;
				edg[0] = it.face_edge_a;
				edg[1] = it.face_edge_b;
				edg[2] = it.face_edge_c;
				for (int j = 0; j < 3; j++) begin
					if (!it.corner_skip[j]) begin
						val = longint'($signed(edge_mem[edg[j]]));
						add_to_vertex(vtx[(j + 1) % 3], val);
						add_to_vertex(vtx[(j + 2) % 3], val);
					end
				end
				return 1'b0;
			end
			etva_pkg::CMD_READ: begin
				avg = 0;
				if (vertex_count[it.face_vertex_a] > 0)
					avg = vertex_sum[it.face_vertex_a]
						/ longint'(vertex_count[it.face_vertex_a]);
				r.vertex_id = it.face_vertex_a;
				r.average   = avg[etva_pkg::VAL_W-1:0];
				r.valence   = vertex_count[it.face_vertex_a][etva_pkg::CNT_W-1:0];
				r.overflow  = overflow_seen;
				return 1'b1;
			end
			default: begin
				clear_vertices();
				return 1'b0;
			end
		endcase
	endfunction

	function automatic etva_pkg::item_t load_item(input int e,
			input logic [etva_pkg::VAL_W-1:0] val);
		etva_pkg::item_t it = '0;
		it.command    = etva_pkg::CMD_LOAD;
		it.edge_index = etva_pkg::EDGE_W'(e);
		it.edge_value = val;
		return it;
	endfunction

	function automatic etva_pkg::item_t face_item(input int va, input int vb, input int vc,
			input int ea, input int eb, input int ec, input logic [2:0] skip);
		etva_pkg::item_t it = '0;
		it.command       = etva_pkg::CMD_FACE;
		it.face_vertex_a = etva_pkg::VERT_W'(va);
		it.face_vertex_b = etva_pkg::VERT_W'(vb);
		it.face_vertex_c = etva_pkg::VERT_W'(vc);
		it.face_edge_a   = etva_pkg::EDGE_W'(ea);
		it.face_edge_b   = etva_pkg::EDGE_W'(eb);
		it.face_edge_c   = etva_pkg::EDGE_W'(ec);
		it.corner_skip   = skip;
		return it;
	endfunction

	function automatic etva_pkg::item_t read_item(input int v);
		etva_pkg::item_t it = '0;
		it.command       = etva_pkg::CMD_READ;
		it.face_vertex_a = etva_pkg::VERT_W'(v);
		return it;
	endfunction

	function automatic etva_pkg::result_t avg_result(input int v,
			input logic [etva_pkg::VAL_W-1:0] avg, input int cnt, input bit ovf);
		etva_pkg::result_t r;
		r.vertex_id = etva_pkg::VERT_W'(v);
		r.average   = avg;
		r.valence   = etva_pkg::CNT_W'(cnt);
		r.overflow  = ovf;
		return r;
	endfunction

	function automatic void add_row(input etva_pkg::item_t it, input int reps = 1);
		stim_row_t row;
		row.it    = it;
		row.reps  = reps;
		row.typed = 1'b0;
		row.want  = '0;
		directed.push_back(row);
	endfunction

	function automatic void add_checked_read(input int v, input etva_pkg::result_t want);
		stim_row_t row;
		row.it    = read_item(v);
		row.reps  = 1;
		row.typed = 1'b1;
		row.want  = want;
		directed.push_back(row);
	endfunction

	function automatic void build_directed();
		etva_pkg::item_t clear_it = '0;
		clear_it.command = etva_pkg::CMD_CLEAR;
		// Fresh stores read back as zero
		add_checked_read(0, avg_result(0, '0, 0, 1'b0));
		add_checked_read(4095, avg_result(4095, '0, 0, 1'b0));
		// Edge value extremes at both ends of the edge store
		add_row(load_item(0, 32'h7FFF_FFFF));
		add_row(load_item(16383, 32'h8000_0000));
		add_row(load_item(5, 32'h0001_0000));
		add_row(load_item(1, 32'hFFFF_FFFD));
		add_row(face_item(1, 2, 3, 0, 16383, 5, 3'b000));
		add_row(read_item(1));
		add_row(read_item(2));
		add_row(read_item(3));
		// Fully skipped and partly skipped faces
		add_row(face_item(1, 2, 3, 0, 1, 5, 3'b111));
		add_row(face_item(1, 2, 3, 1, 0, 16383, 3'b101));
		add_row(read_item(2));
		// Degenerate face: one corner feeds the same vertex twice
		add_row(face_item(10, 10, 11, 1, 1, 0, 3'b000));
		add_row(read_item(10));
		add_row(read_item(11));
		// Most negative average on the top vertex index
		add_row(face_item(4095, 0, 4095, 16383, 16383, 16383, 3'b000));
		add_checked_read(4095, avg_result(4095, 32'h8000_0000, 4, 1'b0));
		// Clear keeps edges but zeroes vertices
		add_row(clear_it);
		add_checked_read(1, avg_result(1, '0, 0, 1'b0));
	endfunction

	// Hand one item to the block and hold it until accepted
	task automatic send_item(input etva_pkg::item_t it, input bit typed,
			input etva_pkg::result_t want);
		etva_pkg::result_t predicted;
		bit                has_result;
		item  <= it;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		has_result = average_predict(it, predicted);
		if (has_result)
			pending_averages.push_back(typed ? want : predicted);
		n_items++;
		if (it.command == etva_pkg::CMD_READ)  n_reads++;
		if (it.command == etva_pkg::CMD_FACE)  n_faces++;
		if (it.command == etva_pkg::CMD_CLEAR) n_clears++;
	endtask

	// Drop start for a random gap: mostly none, some short, a few long
	task automatic random_gap(input bit quiet);
		int roll;
		int len;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 65)
			len = 0;
		else if (roll < 95)
			len = $urandom_range(1, 3);
		else
			len = $urandom_range(10, 40);
		if (len > 0) begin
			start <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	function automatic int pick_vertex();
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(0, 31);
		return $urandom_range(0, etva_pkg::N_VERT - 1);
	endfunction

	function automatic int pick_edge();
		return loaded_edges[$urandom_range(0, loaded_edges.size() - 1)];
	endfunction

	// Well-formed traffic with random content; unused fields carry noise
	function automatic etva_pkg::item_t random_item();
		etva_pkg::item_t it;
		int              roll;
		logic [159:0]    noise;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = noise[$bits(etva_pkg::item_t)-1:0];
		roll = $urandom_range(0, 99);
		if (roll < 25 || loaded_edges.size() == 0) begin
			it.command = etva_pkg::CMD_LOAD;
			if ($urandom_range(0, 9) < 7)
				it.edge_index = etva_pkg::EDGE_W'($urandom_range(0, 63));
		end else if (roll < 67) begin
			it.command       = etva_pkg::CMD_FACE;
			it.face_vertex_a = etva_pkg::VERT_W'(pick_vertex());
			it.face_vertex_b = etva_pkg::VERT_W'(pick_vertex());
			it.face_vertex_c = etva_pkg::VERT_W'(pick_vertex());
			it.face_edge_a   = etva_pkg::EDGE_W'(pick_edge());
			it.face_edge_b   = etva_pkg::EDGE_W'(pick_edge());
			it.face_edge_c   = etva_pkg::EDGE_W'(pick_edge());
		end else if (roll < 98) begin
			it.command       = etva_pkg::CMD_READ;
			it.face_vertex_a = etva_pkg::VERT_W'(pick_vertex());
		end else begin
			it.command = etva_pkg::CMD_CLEAR;
		end
		return it;
	endfunction

	// Compare every strobed result with the oldest expectation
	always @(posedge clk) begin
		etva_pkg::result_t want;
		if (arst_n && done) begin
			n_results++;
			if (pending_averages.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result: vertex %0d average %h valence %0d overflow %0b",
						result.vertex_id, result.average, result.valence, result.overflow);
			end else begin
				want = pending_averages.pop_front();
				if (result.vertex_id !== want.vertex_id || result.average !== want.average ||
						result.valence !== want.valence || result.overflow !== want.overflow) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: want v%0d %h cnt %0d ovf %0b, got v%0d %h cnt %0d ovf %0b",
							want.vertex_id, want.average, want.valence, want.overflow,
							result.vertex_id, result.average, result.valence, result.overflow);
				end
			end
		end
	end

	// Count cycles in which no item and no result moves
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("watchdog expired after %0d quiet cycles", idle_cycles);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		bit quiet;
		arst_n      = 1'b0;
		start       = 1'b0;
		item        = '0;
		idle_cycles = 0;
		overflow_seen = 1'b0;
		clear_vertices();
		build_directed();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (directed[i]) begin
			for (int r = 0; r < directed[i].reps; r++)
				send_item(directed[i].it, directed[i].typed, directed[i].want);
			random_gap(directed[i].reps > 1);
		end

		// Random part, with stretches of back-to-back items
		quiet = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			send_item(random_item(), 1'b0, '0);
			random_gap(quiet);
		end
		start <= 1'b0;

		// Drain outstanding reads, then let the block settle
		while (pending_averages.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d faces, %0d reads, %0d clears; %0d results checked",
			n_items, n_faces, n_reads, n_clears, n_results);
		$display("clears, skipped corners, degenerate faces and edge extremes exercised");
		if (n_mismatch == 0 && pending_averages.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches, %0d results never arrived", n_mismatch,
				pending_averages.size());
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

[edge_to_vertex_average.f]
+incdir+hdl
hdl/etva_pkg.sv
hdl/edge_to_vertex_average.sv
dv/edge_to_vertex_average_tb.sv
